// File: rtl/mvpid_pkg.sv
package mvpid_pkg;

    localparam int NUM_VEHICLES = 4;
    localparam int CORDIC_STEPS = 16;
    localparam int AXES         = 3;
    localparam int NUM_SLOTS    = NUM_VEHICLES * AXES;
    localparam int SLOT_W       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);

    localparam int VID_W  = 2;
    localparam int ERR_W  = 32;
    localparam int INT_W  = 48;
    localparam int MEM_W  = ERR_W + INT_W;
    localparam int CW     = 36;
    localparam int MUL_A_W = 36;
    localparam int MUL_B_W = 33;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam int S_DATA_W = 264;
    localparam int M_DATA_W = 104;

    // gain compensation of the cordic, Q2.30
    localparam logic signed [MUL_B_W-1:0] CORDIC_COMP =
        MUL_B_W'(64'd652032874 + (64'd434688583 >> (2 * CORDIC_STEPS)));

    typedef enum logic [1:0] {
        CFG_GAIN_P   = 2'd0,
        CFG_GAIN_I   = 2'd1,
        CFG_GAIN_D   = 2'd2,
        CFG_ARR_TOL  = 2'd3
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD, ST_ERR, ST_MP, ST_MI, ST_MD, ST_ACC,
        ST_QUAT, ST_CWAIT, ST_MX, ST_MY, ST_YFIN, ST_EMIT
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
        if (v > 72'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -72'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
        if (v > 64'sd140737488355327)
            return 48'sh7fffffffffff;
        else if (v < -64'sd140737488355328)
            return 48'sh800000000000;
        else
            return v[47:0];
    endfunction

endpackage

// File: rtl/mvpid_ram.sv
module mvpid_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             aclk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/mvpid_cordic.sv
module mvpid_cordic (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic signed [mvpid_pkg::CW-1:0] t3_in,
    input  logic signed [mvpid_pkg::CW-1:0] t4_in,
    input  logic signed [mvpid_pkg::CW-1:0] x_in,
    input  logic signed [mvpid_pkg::CW-1:0] y_in,
    output logic                        done,
    output logic signed [mvpid_pkg::CW-1:0] x_out,
    output logic signed [mvpid_pkg::CW-1:0] y_out
);
    import mvpid_pkg::*;

    logic signed [CW-1:0] t3_reg, t4_reg, x_reg, y_reg;
    logic [STEP_W-1:0]    step_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic signed [CW-1:0] sh3, sh4, shx, shy;

    assign sh3 = t3_reg >>> step_reg;
    assign sh4 = t4_reg >>> step_reg;
    assign shx = x_reg >>> step_reg;
    assign shy = y_reg >>> step_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            if (start) begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                step_reg <= '0;
                t3_reg   <= t3_in;
                t4_reg   <= t4_in;
                x_reg    <= x_in;
                y_reg    <= y_in;
            end else if (busy_reg) begin
                // rotate toward t3 == 0, carrying the command vector along
                if (!t3_reg[CW-1]) begin
                    t4_reg <= t4_reg + sh3;
                    t3_reg <= t3_reg - sh4;
                    x_reg  <= x_reg + shy;
                    y_reg  <= y_reg - shx;
                end else begin
                    t4_reg <= t4_reg - sh3;
                    t3_reg <= t3_reg + sh4;
                    x_reg  <= x_reg - shy;
                    y_reg  <= y_reg + shx;
                end
                if (32'(step_reg) == CORDIC_STEPS - 1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    step_reg <= step_reg + 1'b1;
                    done_reg <= 1'b0;
                end
            end else begin
                done_reg <= 1'b0;
            end
        end
    end

    assign done  = done_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
endmodule

// File: rtl/multi_vehicle_pid_position_controller_top.sv
// three-axis pid position controller for up to NUM_VEHICLES vehicles, with the
// x/y command turned into the body frame by minus yaw. one pose beat in gives
// one command beat out (beats for a vehicle id at or above NUM_VEHICLES are
// dropped). per vehicle and axis the previous error and the Q32.16 integral
// live in one synchronous ram, cleared at reset through per-entry valid bits.
// per item, from one accepted pose beat to the next when the output is free,
// each axis passes the ram read and the single shared multiplier (p, i, d
// products one after another), then come the quaternion terms, the wait on
// the cordic, the gain compensation (ST_MX, ST_MY, ST_YFIN), the load of the
// output register and the step back to idle. a degenerate quaternion skips
// the cordic and its gain compensation. a finished result sits in the output
// register, so the next pose beat is taken while it waits.
// config registers may be written only while the block is idle.
module multi_vehicle_pid_position_controller_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // pose in: vehicle_id, pos_x, pos_y, pos_z, target_x, target_y, target_z,
    // quat_w, quat_x, quat_y, quat_z (lowest bits first)
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mvpid_pkg::S_DATA_W-1:0]    s_tdata,
    // command out: out_vehicle_id, vel_x, vel_y, vel_z, arrived (lowest first)
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mvpid_pkg::M_DATA_W-1:0]    m_tdata,
    input  logic                              cfg_wr_en,
    input  logic [1:0]                        cfg_index,
    input  logic [31:0]                       cfg_wdata
);
    import mvpid_pkg::*;

    // config registers
    logic [31:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [30:0] arr_tol_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg  <= 32'd8388608;
            gain_i_reg  <= 32'd3355;
            gain_d_reg  <= 32'd839;
            arr_tol_reg <= 31'd32768;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_GAIN_P:  gain_p_reg  <= cfg_wdata;
                CFG_GAIN_I:  gain_i_reg  <= cfg_wdata;
                CFG_GAIN_D:  gain_d_reg  <= cfg_wdata;
                CFG_ARR_TOL: arr_tol_reg <= cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    state_t state_reg, state_next;

    // latched pose beat
    logic [VID_W-1:0]         vid_reg;
    logic signed [31:0]       pos_reg [AXES];
    logic signed [31:0]       tgt_reg [AXES];
    logic signed [15:0]       qw_reg, qx_reg, qy_reg, qz_reg;
    logic [1:0]               axis_reg;

    // per-axis working values
    logic signed [31:0]       e_reg, d_reg;
    logic signed [INT_W-1:0]  integ_reg, isum_reg;
    logic signed [44:0]       p_reg;
    logic signed [31:0]       u_reg [AXES];
    logic                     inside_reg;
    logic signed [31:0]       rx_reg, ry_reg;

    // shared multiplier
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod_reg;

    // state memory: {integral, previous error}
    logic [NUM_SLOTS-1:0] valid_reg;
    logic [SLOT_W-1:0]    slot;
    logic                 ram_we;
    logic [MEM_W-1:0]     ram_wdata, ram_rdata;

    // output register
    logic                 m_valid_reg;
    logic [M_DATA_W-1:0]  m_data_reg;

    logic in_take;
    assign s_tready = (state_reg == ST_IDLE);
    assign in_take  = s_tvalid && s_tready;

    assign slot = SLOT_W'(32'(vid_reg) * AXES + 32'(axis_reg));

    mvpid_ram #(.WIDTH(MEM_W), .DEPTH(NUM_SLOTS)) u_state_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (slot),
        .wdata (ram_wdata),
        .raddr (slot),
        .rdata (ram_rdata)
    );

    // error path, ram data valid in ST_ERR
    logic signed [31:0]      prev_err;
    logic signed [INT_W-1:0] prev_int;
    logic signed [31:0]      e_now, d_now;
    logic [31:0]             abs_e;

    assign prev_err = valid_reg[slot] ? ram_rdata[ERR_W-1:0] : '0;
    assign prev_int = valid_reg[slot] ? ram_rdata[MEM_W-1:ERR_W] : '0;
    assign e_now = sat32(72'(tgt_reg[axis_reg]) - 72'(pos_reg[axis_reg]));
    assign d_now = sat32(72'(e_now) - 72'(prev_err));
    assign abs_e = e_now[31] ? 32'(-(33'(e_now))) : 32'(e_now);

    // accumulate and sum
    logic signed [INT_W-1:0] isum_now;
    logic signed [31:0]      u_now;
    assign isum_now = sat48(64'(integ_reg) + 64'(prod_reg >>> 8));
    assign u_now = sat32(72'(p_reg) + 72'(isum_reg >>> 16) + 72'(prod_reg >>> 24));

    assign ram_we    = (state_reg == ST_ACC);
    assign ram_wdata = {isum_reg, e_reg};

    // yaw terms, Q2.28
    logic signed [31:0] p_wz, p_xy, p_yy, p_zz;
    logic signed [CW-1:0] t3c, t4c;
    logic degen, half_turn;
    assign p_wz = qw_reg * qz_reg;
    assign p_xy = qx_reg * qy_reg;
    assign p_yy = qy_reg * qy_reg;
    assign p_zz = qz_reg * qz_reg;
    assign t3c  = (CW'(p_wz) + CW'(p_xy)) <<< 1;
    assign t4c  = (CW'(1) <<< 28) - ((CW'(p_yy) + CW'(p_zz)) <<< 1);
    assign degen     = (t3c == '0) && (t4c == '0);
    assign half_turn = t4c[CW-1];

    logic cord_start, cord_done;
    logic signed [CW-1:0] cord_x, cord_y;
    assign cord_start = (state_reg == ST_QUAT) && !degen;

    mvpid_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cord_start),
        .t3_in   (half_turn ? -t3c : t3c),
        .t4_in   (half_turn ? -t4c : t4c),
        .x_in    (half_turn ? -CW'(u_reg[0]) : CW'(u_reg[0])),
        .y_in    (half_turn ? -CW'(u_reg[1]) : CW'(u_reg[1])),
        .done    (cord_done),
        .x_out   (cord_x),
        .y_out   (cord_y)
    );

    logic out_free;
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        mul_a = MUL_A_W'(e_reg);
        mul_b = MUL_B_W'({1'b0, gain_p_reg});
        unique case (state_reg)
            ST_IDLE:  if (in_take && 32'(s_tdata[1:0]) < NUM_VEHICLES) state_next = ST_RD;
            ST_RD:    state_next = ST_ERR;
            ST_ERR:   state_next = ST_MP;
            ST_MP:    state_next = ST_MI;
            ST_MI: begin
                mul_b = MUL_B_W'({1'b0, gain_i_reg});
                state_next = ST_MD;
            end
            ST_MD: begin
                mul_a = MUL_A_W'(d_reg);
                mul_b = MUL_B_W'({1'b0, gain_d_reg});
                state_next = ST_ACC;
            end
            ST_ACC:   state_next = (32'(axis_reg) == AXES - 1) ? ST_QUAT : ST_RD;
            ST_QUAT:  state_next = degen ? ST_EMIT : ST_CWAIT;
            ST_CWAIT: if (cord_done) state_next = ST_MX;
            ST_MX: begin
                mul_a = cord_x;
                mul_b = CORDIC_COMP;
                state_next = ST_MY;
            end
            ST_MY: begin
                mul_a = cord_y;
                mul_b = CORDIC_COMP;
                state_next = ST_YFIN;
            end
            ST_YFIN:  state_next = ST_EMIT;
            ST_EMIT:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
            axis_reg    <= '0;
        end else begin
            if (state_reg == ST_EMIT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == ST_ACC) begin
                valid_reg[slot] <= 1'b1;
                axis_reg <= axis_reg + 1'b1;
            end
            if (state_reg == ST_IDLE) begin
                axis_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (in_take) begin
            vid_reg    <= s_tdata[1:0];
            pos_reg[0] <= s_tdata[33:2];
            pos_reg[1] <= s_tdata[65:34];
            pos_reg[2] <= s_tdata[97:66];
            tgt_reg[0] <= s_tdata[129:98];
            tgt_reg[1] <= s_tdata[161:130];
            tgt_reg[2] <= s_tdata[193:162];
            qw_reg     <= s_tdata[209:194];
            qx_reg     <= s_tdata[225:210];
            qy_reg     <= s_tdata[241:226];
            qz_reg     <= s_tdata[257:242];
            inside_reg <= 1'b1;
        end
        if (state_reg == ST_ERR) begin
            e_reg     <= e_now;
            d_reg     <= d_now;
            integ_reg <= prev_int;
            if (!(abs_e < {1'b0, arr_tol_reg})) begin
                inside_reg <= 1'b0;
            end
        end
        if (state_reg == ST_MI) begin
            p_reg <= 45'(prod_reg >>> 24);
        end
        if (state_reg == ST_MD) begin
            isum_reg <= isum_now;
        end
        if (state_reg == ST_ACC) begin
            u_reg[axis_reg] <= u_now;
        end
        if (state_reg == ST_QUAT && degen) begin
            rx_reg <= u_reg[0];
            ry_reg <= u_reg[1];
        end
        if (state_reg == ST_MY) begin
            rx_reg <= sat32(72'(prod_reg >>> 30));
        end
        if (state_reg == ST_YFIN) begin
            ry_reg <= sat32(72'(prod_reg >>> 30));
        end
        if (state_reg == ST_EMIT && out_free) begin
            m_data_reg <= {5'd0, inside_reg, u_reg[2], ry_reg, rx_reg, vid_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import mvpid_pkg::*;

    // pose beat fields, as they sit in s_tdata
    typedef struct {
        logic [1:0]         vid;
        logic signed [31:0] pos_x, pos_y, pos_z;
        logic signed [31:0] tgt_x, tgt_y, tgt_z;
        logic signed [15:0] qw, qx, qy, qz;
    } pose_t;

    // command beat fields, as they sit in m_tdata
    typedef struct {
        logic [1:0]         vid;
        logic signed [31:0] vel_x, vel_y, vel_z;
        logic               arrived;
    } cmd_t;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 60;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_wr_en;
    logic [1:0]            cfg_index;
    logic [31:0]           cfg_wdata;

    multi_vehicle_pid_position_controller_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // 8 ns clock
    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // shadow of the config registers
    logic [31:0] gain_p, gain_i, gain_d;
    logic [30:0] tol;

    // per vehicle and axis controller memory, slot = vehicle*3 + axis
    longint last_err [NUM_SLOTS];
    longint integ    [NUM_SLOTS];

    cmd_t   pending_cmds[$];
    int     errors;
    int     idle_cycles;
    int     burst_left;
    bit     hold_off;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint clamp48(longint v);
        if (v > 64'sd140737488355327)
            return 64'sd140737488355327;
        if (v < -64'sd140737488355328)
            return -64'sd140737488355328;
        return v;
    endfunction

    // pid step for one pose, then body-frame rotation by minus yaw
    function automatic cmd_t pid_command(pose_t p);
        cmd_t   c;
        longint pos[3], tgt[3], u[3];
        longint e, d, pt, it, dt;
        longint w, x, y, z, t3, t4, cx, cy, n3, n4, nx, ny, comp;
        int     k;
        bit     in_tol;
        pos[0] = p.pos_x; pos[1] = p.pos_y; pos[2] = p.pos_z;
        tgt[0] = p.tgt_x; tgt[1] = p.tgt_y; tgt[2] = p.tgt_z;
        in_tol = 1'b1;
        for (int a = 0; a < 3; a++) begin
            k  = p.vid * 3 + a;
            e  = clamp32(tgt[a] - pos[a]);
            d  = clamp32(e - last_err[k]);
            pt = (longint'(gain_p) * e) >>> 24;
            it = clamp48(integ[k] + ((longint'(gain_i) * e) >>> 8));
            dt = (longint'(gain_d) * d) >>> 24;
            integ[k]    = it;
            last_err[k] = e;
            u[a] = clamp32(pt + (it >>> 16) + dt);
            if (!((e < 0 ? -e : e) < longint'(tol)))
                in_tol = 1'b0;
        end
        w = p.qw; x = p.qx; y = p.qy; z = p.qz;
        t3 = 2 * (w * z + x * y);
        t4 = (64'sd1 <<< 28) - 2 * (y * y + z * z);
        cx = u[0];
        cy = u[1];
        if (t3 != 0 || t4 != 0) begin
            comp = 64'sd652032874 + longint'(64'd434688583 >> (2 * CORDIC_STEPS));
            // negative cosine term: start with a half turn
            if (t4 < 0) begin
                t3 = -t3; t4 = -t4; cx = -cx; cy = -cy;
            end
            for (int s = 0; s < CORDIC_STEPS; s++) begin
                if (t3 >= 0) begin
                    n4 = t4 + (t3 >>> s); n3 = t3 - (t4 >>> s);
                    nx = cx + (cy >>> s); ny = cy - (cx >>> s);
                end else begin
                    n4 = t4 - (t3 >>> s); n3 = t3 + (t4 >>> s);
                    nx = cx - (cy >>> s); ny = cy + (cx >>> s);
                end
                t4 = n4; t3 = n3; cx = nx; cy = ny;
            end
            cx = clamp32((cx * comp) >>> 30);
            cy = clamp32((cy * comp) >>> 30);
        end
        c.vid     = p.vid;
        c.vel_x   = cx[31:0];
        c.vel_y   = cy[31:0];
        c.vel_z   = u[2][31:0];
        c.arrived = in_tol;
        return c;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // one pose beat; the sender idles between bursts of random length
    task automatic send_pose(pose_t p);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 25);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, p.qz, p.qy, p.qx, p.qw, p.tgt_z, p.tgt_y, p.tgt_x,
                     p.pos_z, p.pos_y, p.pos_x, p.vid};
        do @(posedge aclk); while (!s_tready);
        pending_cmds = {pending_cmds, pid_command(p)};
    endtask

    // lower valid and wait until every command has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_cmds.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_GAIN_P:  gain_p = val;
            CFG_GAIN_I:  gain_i = val;
            CFG_GAIN_D:  gain_d = val;
            CFG_ARR_TOL: tol    = val[30:0];
            default: ;
        endcase
    endtask

    task automatic set_gains(logic [31:0] gp, logic [31:0] gi, logic [31:0] gd,
                             logic [31:0] t);
        drain();
        write_reg(CFG_GAIN_P, gp);
        write_reg(CFG_GAIN_I, gi);
        write_reg(CFG_GAIN_D, gd);
        write_reg(CFG_ARR_TOL, t);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic signed [15:0] rand_quat();
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    // mostly small tracking errors so the integral and arrival paths get used,
    // sometimes fully random positions that drive the saturation paths
    function automatic pose_t rand_pose();
        pose_t p;
        int    span;
        p.vid   = 2'($urandom_range(0, 3));
        p.pos_x = $urandom; p.pos_y = $urandom; p.pos_z = $urandom;
        case ($urandom_range(0, 9))
            0, 1: begin
                p.tgt_x = $urandom; p.tgt_y = $urandom; p.tgt_z = $urandom;
            end
            default: begin
                span = ($urandom_range(0, 2) == 0) ? 2000000 : 40000;
                p.tgt_x = p.pos_x + ($signed($urandom_range(0, 2 * span)) - span);
                p.tgt_y = p.pos_y + ($signed($urandom_range(0, 2 * span)) - span);
                p.tgt_z = p.pos_z + ($signed($urandom_range(0, 2 * span)) - span);
            end
        endcase
        p.qw = rand_quat(); p.qx = rand_quat(); p.qy = rand_quat(); p.qz = rand_quat();
        return p;
    endfunction

    function automatic pose_t make_pose(int vid, int px, int tx,
                                        int qw, int qx, int qy, int qz);
        pose_t p;
        p.vid = 2'(vid);
        p.pos_x = px; p.pos_y = -px; p.pos_z = px;
        p.tgt_x = tx; p.tgt_y = -tx; p.tgt_z = tx;
        p.qw = 16'(qw); p.qx = 16'(qx); p.qy = 16'(qy); p.qz = 16'(qz);
        return p;
    endfunction

    // extremes, every vehicle, half-turn and degenerate quaternions
    task automatic test_directed();
        send_pose(make_pose(0, 0, 0, 16384, 0, 0, 0));
        send_pose(make_pose(1, 32'sh7fffffff, 32'sh80000000, 16384, 0, 0, 0));
        send_pose(make_pose(2, 32'sh80000000, 32'sh7fffffff, 16384, 0, 0, 0));
        send_pose(make_pose(3, 1000, 1100, 16384, 0, 0, 0));
        // large errors of both signs back to back hit the difference clamp
        send_pose(make_pose(1, 32'sh80000000, 32'sh7fffffff, 0, 0, 0, 16384));
        send_pose(make_pose(1, 32'sh7fffffff, 32'sh80000000, 0, 0, 0, -16384));
        // degenerate quaternion gives yaw of zero
        send_pose(make_pose(0, 0, 65536 * 3, 0, 0, 8192, 8192));
        send_pose(make_pose(2, 5, -700000, 0, 0, -8192, 8192));
        // negative cosine term
        send_pose(make_pose(3, -65536, 65536, 0, 0, 16384, 16384));
        send_pose(make_pose(0, 12345, -54321, -16384, 16384, -16384, -16384));
        send_pose(make_pose(2, 32'sh7fffffff, 32'sh7fffffff, 11585, 0, 0, 11585));
        send_pose(make_pose(3, 0, 32767, -16384, -16384, -16384, 16384));
        send_pose(make_pose(3, 0, 32768, 11585, 0, 0, -11585));
        for (int v = 0; v < 4; v++)
            send_pose(make_pose(v, 100 * v, 100 * v + 20, 16384, 0, 0, 0));
    endtask

    task automatic test_random(int n);
        repeat (n) send_pose(rand_pose());
    endtask

    task automatic test_config_sweep();
        set_gains(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'h7fffffff);
        test_directed();
        test_random(150);
        set_gains(32'h0, 32'h0, 32'h0, 32'h0);
        test_random(100);
        set_gains(32'h01000000, 32'h00100000, 32'h00800000, 32'h00010000);
        test_random(300);
        set_gains($urandom, $urandom, $urandom, $urandom_range(0, 200000));
        test_random(200);
        set_gains(32'd8388608, 32'd3355, 32'd839, 32'd32768);
    endtask

    // receiver holds off long enough that the block fills and stalls its input
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (800) @(posedge aclk);
                hold_off = 1'b0;
            end
            test_random(40);
        join
    endtask

    // receiver: ready pattern switches between modes of random length
    int rx_mode, rx_left;
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(5, 150);
        end
        rx_left--;
        if (hold_off)
            m_tready <= 1'b0;
        else case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= $urandom_range(0, 1);
        endcase
    end

    // command checker and watchdog
    always @(posedge aclk) begin
        cmd_t want;
        if (aresetn) begin
            idle_cycles++;
            if (s_tvalid && s_tready)
                idle_cycles = 0;
            if (m_tvalid && m_tready) begin
                idle_cycles = 0;
                if (pending_cmds.size() == 0) begin
                    report_mismatch("unexpected beat", 1, 0);
                end else begin
                    want = pending_cmds.pop_front();
                    if (m_tdata[1:0] !== want.vid)
                        report_mismatch("vehicle", m_tdata[1:0], want.vid);
                    if (m_tdata[33:2] !== want.vel_x)
                        report_mismatch("vel_x", $signed(m_tdata[33:2]), want.vel_x);
                    if (m_tdata[65:34] !== want.vel_y)
                        report_mismatch("vel_y", $signed(m_tdata[65:34]), want.vel_y);
                    if (m_tdata[97:66] !== want.vel_z)
                        report_mismatch("vel_z", $signed(m_tdata[97:66]), want.vel_z);
                    if (m_tdata[98] !== want.arrived)
                        report_mismatch("arrived", m_tdata[98], want.arrived);
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb failed");
                $finish;
            end
        end
    end

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_GAIN_P;
        cfg_wdata = '0;
        errors = 0; idle_cycles = 0; burst_left = 0; hold_off = 1'b0;
        rx_mode = 0; rx_left = 0;
        gain_p = 32'd8388608; gain_i = 32'd3355; gain_d = 32'd839; tol = 31'd32768;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            last_err[k] = 0;
            integ[k]    = 0;
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (4) @(posedge aclk);

        test_directed();
        test_random(300);
        test_backpressure();
        test_config_sweep();
        test_random(700);

        drain();
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
